FILE: src/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
`timescale 1ns / 1ps

package bale_pkg;

	// default list capacity
	localparam int CAPACITY_DEF = 16;

	// payload field widths
	localparam int OP_W   = 3;
	localparam int POS_W  = 4;
	localparam int VAL_W  = 8;
	localparam int ST_W   = 2;
	localparam int CNTO_W = 5;

	// request codes
	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_SORTED = 3'd4;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd5;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

endpackage

FILE: src/bale_req_if.sv
// Request channel interface of the list engine.
`timescale 1ns / 1ps

interface bale_req_if;
	logic                        valid;
	logic                        ready;
	logic [bale_pkg::OP_W-1:0]   operation;
	logic [bale_pkg::POS_W-1:0]  position;
	logic                        at_end;
	logic [bale_pkg::VAL_W-1:0]  byte_value;

	modport source (output valid, operation, position, at_end, byte_value, input ready);
	modport sink   (input valid, operation, position, at_end, byte_value, output ready);
endinterface

FILE: src/bale_rsp_if.sv
// Result channel interface of the list engine.
`timescale 1ns / 1ps

interface bale_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bale_pkg::VAL_W-1:0]   read_data;
	logic                         found;
	logic [bale_pkg::POS_W-1:0]   found_position;
	logic [bale_pkg::ST_W-1:0]    status;
	logic [bale_pkg::CNTO_W-1:0]  entry_count;

	modport source (output valid, read_data, found, found_position, status, entry_count,
		input ready);
	modport sink   (input valid, read_data, found, found_position, status, entry_count,
		output ready);
endinterface

FILE: src/bale_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bale_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/bounded_array_list_engine_top.sv
// Top level of the bounded array list engine: sequencer around one entry RAM.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY bytes held in a single-port-read RAM, walked by a
// small sequencer that shares one byte comparator. One request is taken at a time;
// req.ready is high only while the engine is idle. Every entry that is scanned or
// shifted takes a RAM read step, then a compare or write-back step, because the RAM
// has one registered read port. The result sits in an output register, so a new
// request is taken while the previous result waits. Entries at or above the count
// are never read, so the RAM needs no clearing pass after reset.
module bounded_array_list_engine_top #(
	parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bale_req_if.sink     req,
	bale_rsp_if.source   rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > bale_pkg::CNTO_W) ? CNT_W : bale_pkg::CNTO_W;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_RD_WAIT = 11'b000_0000_0010,
		S_SHUP_RD = 11'b000_0000_0100,
		S_SHUP_WR = 11'b000_0000_1000,
		S_SHDN_RD = 11'b000_0001_0000,
		S_SHDN_WR = 11'b000_0010_0000,
		S_SCAN_RD = 11'b000_0100_0000,
		S_SCAN_CMP= 11'b000_1000_0000,
		S_PUT     = 11'b001_0000_0000,
		S_CLR     = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] tgt_q, tgt_d;
	logic [bale_pkg::OP_W-1:0]  op_q, op_d;
	logic [bale_pkg::VAL_W-1:0] val_q, val_d;

	// working result
	logic [bale_pkg::VAL_W-1:0] rd_q, rd_d;
	logic                       fnd_q, fnd_d;
	logic [bale_pkg::POS_W-1:0] fpos_q, fpos_d;
	bale_pkg::status_t          st_q, st_d;

	// output register
	logic                        rsp_vld_q;
	logic [bale_pkg::VAL_W-1:0]  out_rd_q;
	logic                        out_fnd_q;
	logic [bale_pkg::POS_W-1:0]  out_fpos_q;
	bale_pkg::status_t           out_st_q;
	logic [bale_pkg::CNTO_W-1:0] out_cnt_q;
	logic                        out_load;

	// RAM port
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [bale_pkg::VAL_W-1:0] mem_wdata;
	logic [IDX_W-1:0]           mem_raddr;
	logic [bale_pkg::VAL_W-1:0] mem_rdata;

	logic [CNT_W-1:0] idx_inc, idx_dec, cnt_dec;
	logic [CW-1:0]    pos_w, idx_w, cnt_w;
	logic [CNT_W-1:0] pos_idx;
	logic             empty, full, out_rng;
	logic             cmp_ge, cmp_eq;

	bale_ram #(
		.WIDTH (bale_pkg::VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// index arithmetic and request checks
	assign idx_inc = idx_q + CNT_W'(1);
	assign idx_dec = idx_q - CNT_W'(1);
	assign cnt_dec = cnt_q - CNT_W'(1);
	assign pos_w   = CW'(req.position);
	assign idx_w   = CW'(idx_q);
	assign cnt_w   = CW'(cnt_q);
	assign pos_idx = pos_w[CNT_W-1:0];
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign out_rng = (pos_w >= cnt_w);

	// shared compare unit
	assign cmp_ge = (val_q >= mem_rdata);
	assign cmp_eq = (val_q == mem_rdata);

	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	// sequencer
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		tgt_d     = tgt_q;
		op_d      = op_q;
		val_d     = val_q;
		rd_d      = rd_q;
		fnd_d     = fnd_q;
		fpos_d    = fpos_q;
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = idx_q[IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d    = req.operation;
					val_d   = req.byte_value;
					rd_d    = '0;
					fnd_d   = 1'b0;
					fpos_d  = '0;
					st_d    = bale_pkg::ST_OK;
					state_d = S_DONE;
					unique case (req.operation)
						bale_pkg::OP_READ: begin
							if (empty) begin
								st_d = bale_pkg::ST_EMPTY;
							end else if (out_rng) begin
								st_d = bale_pkg::ST_RANGE;
							end else begin
								mem_raddr = pos_idx[IDX_W-1:0];
								state_d   = S_RD_WAIT;
							end
						end
						bale_pkg::OP_WRITE: begin
							if (empty) begin
								st_d = bale_pkg::ST_EMPTY;
							end else if (out_rng) begin
								st_d = bale_pkg::ST_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = pos_idx[IDX_W-1:0];
								mem_wdata = req.byte_value;
							end
						end
						bale_pkg::OP_INSERT: begin
							if (full) begin
								st_d = bale_pkg::ST_FULL;
							end else if (req.at_end || empty) begin
								tgt_d   = cnt_q;
								state_d = S_PUT;
							end else if (out_rng) begin
								st_d = bale_pkg::ST_RANGE;
							end else begin
								tgt_d   = pos_idx;
								idx_d   = cnt_q;
								state_d = S_SHUP_RD;
							end
						end
						bale_pkg::OP_REMOVE: begin
							if (empty) begin
								st_d = bale_pkg::ST_EMPTY;
							end else if (req.at_end) begin
								idx_d   = cnt_dec;
								state_d = S_SHDN_RD;
							end else if (out_rng) begin
								st_d = bale_pkg::ST_RANGE;
							end else begin
								idx_d   = pos_idx;
								state_d = S_SHDN_RD;
							end
						end
						bale_pkg::OP_SORTED: begin
							if (full) begin
								st_d = bale_pkg::ST_FULL;
							end else begin
								idx_d   = '0;
								state_d = S_SCAN_RD;
							end
						end
						bale_pkg::OP_LOCATE: begin
							idx_d   = '0;
							state_d = S_SCAN_RD;
						end
						default: begin
							// unused codes: empty result, list untouched
						end
					endcase
				end
			end

			// registered read data of a read request
			S_RD_WAIT: begin
				rd_d    = mem_rdata;
				state_d = S_DONE;
			end

			// open a slot at tgt: move entries up one, top first
			S_SHUP_RD: begin
				if (idx_q == tgt_q) begin
					state_d = S_PUT;
				end else begin
					mem_raddr = idx_dec[IDX_W-1:0];
					state_d   = S_SHUP_WR;
				end
			end
			S_SHUP_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_dec;
				state_d = S_SHUP_RD;
			end

			// close the slot at idx: move later entries down one
			S_SHDN_RD: begin
				if (idx_inc >= cnt_q) begin
					state_d = S_CLR;
				end else begin
					mem_raddr = idx_inc[IDX_W-1:0];
					state_d   = S_SHDN_WR;
				end
			end
			S_SHDN_WR: begin
				mem_we  = 1'b1;
				idx_d   = idx_inc;
				state_d = S_SHDN_RD;
			end

			// walk entries from the bottom for sorted insert or locate
			S_SCAN_RD: begin
				if (idx_q == cnt_q) begin
					if (op_q == bale_pkg::OP_SORTED) begin
						tgt_d   = idx_q;
						state_d = S_PUT;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (op_q == bale_pkg::OP_SORTED) begin
					if (cmp_ge) begin
						idx_d   = idx_inc;
						state_d = S_SCAN_RD;
					end else begin
						tgt_d   = idx_q;
						idx_d   = cnt_q;
						state_d = S_SHUP_RD;
					end
				end else if (cmp_eq) begin
					fnd_d   = 1'b1;
					fpos_d  = idx_w[bale_pkg::POS_W-1:0];
					state_d = S_DONE;
				end else begin
					idx_d   = idx_inc;
					state_d = S_SCAN_RD;
				end
			end

			// place the new byte
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = tgt_q[IDX_W-1:0];
				mem_wdata = val_q;
				cnt_d     = cnt_q + CNT_W'(1);
				state_d   = S_DONE;
			end

			// clear the freed top slot
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_dec[IDX_W-1:0];
				mem_wdata = '0;
				cnt_d     = cnt_dec;
				state_d   = S_DONE;
			end

			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			if (out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tgt_q  <= tgt_d;
		op_q   <= op_d;
		val_q  <= val_d;
		rd_q   <= rd_d;
		fnd_q  <= fnd_d;
		fpos_q <= fpos_d;
		st_q   <= st_d;
		if (out_load) begin
			out_rd_q   <= rd_q;
			out_fnd_q  <= fnd_q;
			out_fpos_q <= fpos_q;
			out_st_q   <= st_q;
			out_cnt_q  <= cnt_w[bale_pkg::CNTO_W-1:0];
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.read_data      = out_rd_q;
	assign rsp.found          = out_fnd_q;
	assign rsp.found_position = out_fpos_q;
	assign rsp.status         = out_st_q;
	assign rsp.entry_count    = out_cnt_q;

	// count stays within capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// count moves only when a byte is placed or a slot freed
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_PUT && state_q != S_CLR) |=> $stable(cnt_q))
		else $error("entry count changed outside put or clear");

	// no RAM write while idle with no request offered
	a_idle_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !req.valid) |-> !mem_we)
		else $error("RAM write while idle");

	// an accepted request leaves the idle state
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("ready right after accept");

endmodule

FILE: sim/bale_list_checker.sv
// Scoreboard for the list engine: mirrors the list state, predicts every result and compares.
`timescale 1ns / 1ps

module bale_list_checker #(
	parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bale_req_if         req,
	bale_rsp_if         rsp,
	output int unsigned fault_count,
	output int unsigned pending_results,
	output int unsigned list_size
);

	import bale_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0]  read_data;
		logic              found;
		logic [POS_W-1:0]  found_position;
		status_t           status;
		logic [CNTO_W-1:0] entry_count;
	} list_result_t;

	// shadow copy of the list
	logic [VAL_W-1:0] list_bytes [CAPACITY];
	int unsigned      list_len;

	list_result_t     expected_results [$];
	list_result_t     want;
	int               i;

	task automatic report_mismatch(input string msg);
		$display("%0t list check: %s", $time, msg);
		fault_count++;
	endtask

	function automatic status_t index_status(input logic [POS_W-1:0] pos);
		if (list_len == 0)
			return ST_EMPTY;
		if (pos >= list_len)
			return ST_RANGE;
		return ST_OK;
	endfunction

	// open a slot at k, later entries move up
	task automatic shift_in(input int unsigned k, input logic [VAL_W-1:0] val);
		int unsigned j;
		for (j = list_len; j > k; j--)
			list_bytes[j] = list_bytes[j-1];
		list_bytes[k] = val;
		list_len++;
	endtask

	// close the slot at k, later entries move down, freed slot cleared
	task automatic shift_out(input int unsigned k);
		int unsigned j;
		for (j = k; j + 1 < list_len; j++)
			list_bytes[j] = list_bytes[j+1];
		list_len--;
		list_bytes[list_len] = '0;
	endtask

	// apply one request to the shadow list and work out its result
	task automatic apply_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic at_end, input logic [VAL_W-1:0] val, output list_result_t res);
		int unsigned k;
		res = '0;
		res.status = ST_OK;
		case (op)
			OP_READ: begin
				res.status = index_status(pos);
				if (res.status == ST_OK)
					res.read_data = list_bytes[pos];
			end
			OP_WRITE: begin
				res.status = index_status(pos);
				if (res.status == ST_OK)
					list_bytes[pos] = val;
			end
			OP_INSERT: begin
				if (list_len >= CAPACITY)
					res.status = ST_FULL;
				else if (at_end || list_len == 0)
					shift_in(list_len, val);
				else if (pos >= list_len)
					res.status = ST_RANGE;
				else
					shift_in(pos, val);
			end
			OP_REMOVE: begin
				if (at_end) begin
					if (list_len == 0)
						res.status = ST_EMPTY;
					else
						shift_out(list_len - 1);
				end else begin
					res.status = index_status(pos);
					if (res.status == ST_OK)
						shift_out(pos);
				end
			end
			OP_SORTED: begin
				if (list_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					k = 0;
					while (k < list_len && val >= list_bytes[k])
						k++;
					shift_in(k, val);
				end
			end
			OP_LOCATE: begin
				for (k = 0; k < list_len; k++) begin
					if (!res.found && list_bytes[k] == val) begin
						res.found = 1'b1;
						res.found_position = k[POS_W-1:0];
					end
				end
			end
			default: ;
		endcase
		res.entry_count = list_len[CNTO_W-1:0];
	endtask

	// predict on every accepted request, compare every accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < CAPACITY; i++)
				list_bytes[i] = '0;
			list_len = 0;
			expected_results.delete();
			pending_results <= 0;
			list_size <= 0;
		end else begin
			if (req.valid && req.ready) begin
				apply_request(req.operation, req.position, req.at_end, req.byte_value, want);
				expected_results.push_back(want);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_results.pop_front();
					if (rsp.read_data !== want.read_data)
						report_mismatch($sformatf("read_data got %0h want %0h",
							rsp.read_data, want.read_data));
					if (rsp.found !== want.found)
						report_mismatch($sformatf("found got %0b want %0b",
							rsp.found, want.found));
					if (rsp.found_position !== want.found_position)
						report_mismatch($sformatf("found_position got %0d want %0d",
							rsp.found_position, want.found_position));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							rsp.status, want.status));
					if (rsp.entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count got %0d want %0d",
							rsp.entry_count, want.entry_count));
				end
			end
			pending_results <= expected_results.size();
			list_size <= list_len;
		end
	end

endmodule

FILE: sim/tb_bounded_array_list_engine_top.sv
// Testbench top for the list engine: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_bounded_array_list_engine_top;

	import bale_pkg::*;

	localparam int CAPACITY = 16;
	localparam int RANDOM_ITEMS = 2000;

	// codes the engine ignores
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	// traffic trends for the random part
	localparam int TREND_GROW  = 0;
	localparam int TREND_DRAIN = 1;
	localparam int TREND_MIXED = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        quiet_mode;
	int unsigned fault_count;
	int unsigned pending_results;
	int unsigned list_size;
	int          trend;
	int          n;

	bale_req_if req_ch ();
	bale_rsp_if rsp_ch ();

	bounded_array_list_engine_top #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bale_list_checker #(
		.CAPACITY(CAPACITY)
	) i_list_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.fault_count     (fault_count),
		.pending_results (pending_results),
		.list_size       (list_size)
	);

	always #1 clk = ~clk;

	// offer one item, return at the edge where it is taken
	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic at_end, input logic [VAL_W-1:0] val);
		int gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.operation  <= op;
		req_ch.position   <= pos;
		req_ch.at_end     <= at_end;
		req_ch.byte_value <= val;
		req_ch.valid      <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// hold off new items until every outstanding result is back
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_operation(input int mode);
		int r;
		int ins_w;
		int srt_w;
		int rem_w;
		case (mode)
			TREND_GROW:  begin ins_w = 35; srt_w = 25; rem_w = 12; end
			TREND_DRAIN: begin ins_w = 10; srt_w = 5;  rem_w = 45; end
			default:     begin ins_w = 20; srt_w = 12; rem_w = 30; end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_w)
			return OP_INSERT;
		if (r < ins_w + srt_w)
			return OP_SORTED;
		if (r < ins_w + srt_w + rem_w)
			return OP_REMOVE;
		r = $urandom_range(0, 49);
		if (r < 14)
			return OP_READ;
		if (r < 26)
			return OP_WRITE;
		if (r < 47)
			return OP_LOCATE;
		return (r < 48) ? OP_SPARE_A : OP_SPARE_B;
	endfunction

	// narrow pools make duplicates, so locate hits and sorted ties show up
	function automatic logic [VAL_W-1:0] pick_byte();
		case ($urandom_range(0, 3))
			2:       return VAL_W'($urandom_range(0, 7));
			3:       return VAL_W'($urandom_range(248, 255));
			default: return VAL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly positions inside the list, some anywhere
	function automatic logic [POS_W-1:0] pick_position();
		if (list_size != 0 && $urandom_range(0, 3) != 0)
			return POS_W'($urandom_range(0, list_size - 1));
		return POS_W'($urandom_range(0, 15));
	endfunction

	// result side: random stall before each item
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = quiet_mode ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready))
				@(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		arst_n            = 1'b0;
		quiet_mode        = 1'b0;
		trend             = TREND_MIXED;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_READ;
		req_ch.position   = '0;
		req_ch.at_end     = 1'b0;
		req_ch.byte_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every access flags, locate misses
		send_request(OP_READ,   4'd0,  1'b0, 8'h00);
		send_request(OP_WRITE,  4'd15, 1'b0, 8'hFF);
		send_request(OP_REMOVE, 4'd0,  1'b0, 8'h00);
		send_request(OP_REMOVE, 4'd0,  1'b1, 8'h00);
		send_request(OP_LOCATE, 4'd0,  1'b0, 8'h00);
		// indexed insert on an empty list appends whatever the position
		send_request(OP_INSERT, 4'd9,  1'b0, 8'h80);
		// indexed insert past the end is out of range
		send_request(OP_INSERT, 4'd1,  1'b0, 8'h11);
		send_request(OP_INSERT, 4'd15, 1'b1, 8'hFF);
		send_request(OP_INSERT, 4'd0,  1'b0, 8'h00);
		// sorted: tie goes after equals, so a top tie appends and a bottom tie lands second
		send_request(OP_SORTED, 4'd0,  1'b0, 8'h80);
		send_request(OP_SORTED, 4'd0,  1'b0, 8'hFF);
		send_request(OP_SORTED, 4'd0,  1'b0, 8'h00);
		send_request(OP_READ,   4'd15, 1'b0, 8'h00);
		send_request(OP_READ,   4'd0,  1'b0, 8'h00);
		send_request(OP_WRITE,  4'd2,  1'b0, 8'h55);
		send_request(OP_LOCATE, 4'd0,  1'b0, 8'hFF);
		send_request(OP_LOCATE, 4'd0,  1'b0, 8'h12);
		send_request(OP_SPARE_A, 4'd15, 1'b1, 8'hFF);
		send_request(OP_SPARE_B, 4'd0,  1'b0, 8'h00);
		send_request(OP_REMOVE, 4'd1,  1'b0, 8'h00);
		send_request(OP_REMOVE, 4'd7,  1'b1, 8'h00);
		send_request(OP_READ,   4'd4,  1'b0, 8'h00);
		wait_for_drain();

		// random traffic in phases of fill, drain and mixed use
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				trend = $urandom_range(TREND_GROW, TREND_MIXED);
				quiet_mode <= ($urandom_range(0, 3) == 0);
			end
			if (n == RANDOM_ITEMS / 2)
				wait_for_drain();
			send_request(pick_operation(trend), pick_position(), 1'($urandom_range(0, 1)),
				pick_byte());
		end
		wait_for_drain();
		// room for any stray result to show up
		repeat (40) @(posedge clk);

		if (fault_count == 0 && pending_results == 0)
			$display("tb_bounded_array_list_engine_top: clean");
		else
			$display("tb_bounded_array_list_engine_top: errors");
		$finish;
	end

	// hang guard
	initial begin
		#2000000;
		$display("tb_bounded_array_list_engine_top: errors");
		$finish;
	end

endmodule

FILE: files.f
src/bale_pkg.sv
src/bale_req_if.sv
src/bale_rsp_if.sv
src/bale_ram.sv
src/bounded_array_list_engine_top.sv
sim/bale_list_checker.sv
sim/tb_bounded_array_list_engine_top.sv
